>>> hw/rtl/ptwa_pkg.sv
// Package for the packet time window assigner: widths, result codes and the
// command and status structs between the controller and the datapath.
// Depends on nothing; every other file of the block uses it.
package ptwa_pkg;

  // Field widths.
  localparam int TS_W    = 64;  // packet start timestamp
  localparam int NS_W    = 10;  // samples per packet
  localparam int CHUNK_W = 54;  // chunk numbers
  localparam int CPS_W   = 16;  // counts-per-sample register
  localparam int DATA_W  = 32;  // configuration data bus
  localparam int ADDR_W  = 3;   // configuration byte address

  // Serial divider: the divisor is counts-per-sample times the chunk length,
  // dividends: the timestamp, and it plus the bias that rounds the end up.
  localparam int DIV_W  = 32;
  localparam int DVD_W  = TS_W + 2;
  localparam int CNT_W  = $clog2(DVD_W);
  localparam int SPAN_W = 17;            // samples plus chunk length minus one
  localparam int BIAS_W = SPAN_W + CPS_W;

  // Defaults.
  localparam int                CHUNK_SAMPLES_DEF = 1024;
  localparam logic [CPS_W-1:0]  CPS_RESET         = 16'd384;

  // Register indexes.
  localparam logic REG_CPS = 1'b0;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_PLACED     = 3'd0,
    ST_DROPPED    = 3'd1,
    ST_STRADDLE   = 3'd2,
    ST_AFTER_END  = 3'd3,
    ST_FLUSH      = 3'd4,
    ST_DOUBLE_END = 3'd5
  } status_t;

  // Kind of result the datapath loads into the output register.
  typedef enum logic [2:0] {
    K_PACKET     = 3'd0,
    K_AFTER_END  = 3'd1,
    K_DOUBLE_END = 3'd2,
    K_FLUSH_NONE = 3'd3,
    K_FLUSH_OLD  = 3'd4,
    K_FLUSH_NEW  = 3'd5
  } res_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;   // latch the input transaction, start the division
    logic      step;      // one division step
    logic      advance;   // set up the window and advance it if needed
    logic      started;   // window already set up
    logic      out_load;  // load the output register
    res_kind_t kind;      // what to load
  } ptwa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;       // the current step is the last of the division
  } ptwa_stat_t;

endpackage

>>> hw/rtl/packet_time_window_assigner.sv
// Top level of the packet time window assigner: configuration port,
// controller and datapath. Uses ptwa_pkg, ptwa_cfg, ptwa_ctrl and ptwa_dp.
//
//   Channel   Direction  Handshake          Payload
//   in_       input      in_valid/in_ready  cmd, packet_count, sample_count
//   out_      output     out_valid/ready    status, target_chunk, emitted,
//                                           emitted_chunk, last
//   APB       config     psel/penable       counts_per_sample at address 0
//
// A packet header passes from acceptance through the two-lane restoring
// divider (timestamp over counts-per-sample times the chunk length, for the
// start and the rounded-up end chunk), the window update and the loading
// of the result. An end of stream or a packet after the end skips the
// divider; a started window's flush emits the older, then the newer chunk.
// Reset is synchronous and active low; it returns the register to 384 and
// clears the window. The input stalls while an item is in work; a waiting
// result stalls only the loading of the next result, not the division.
module packet_time_window_assigner #(
  parameter int CHUNK_SAMPLES = ptwa_pkg::CHUNK_SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input transactions.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [ptwa_pkg::TS_W-1:0]      in_packet_count,
  input  logic [ptwa_pkg::NS_W-1:0]      in_sample_count,
  // Result transactions.
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_status,
  output logic [ptwa_pkg::CHUNK_W-1:0]   out_target_chunk,
  output logic                           out_emitted,
  output logic [ptwa_pkg::CHUNK_W-1:0]   out_emitted_chunk,
  output logic                           out_last,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ptwa_pkg::ADDR_W-1:0]    paddr,
  input  logic [ptwa_pkg::DATA_W-1:0]    pwdata,
  output logic [ptwa_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  logic [ptwa_pkg::CPS_W-1:0] cps;
  ptwa_pkg::ptwa_cmd_t        cmd;
  ptwa_pkg::ptwa_stat_t       stat;

  // Configuration registers.
  ptwa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cps     (cps)
  );

  // Sequencer.
  ptwa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Divider, window and output register.
  ptwa_dp #(
    .CHUNK_SAMPLES (CHUNK_SAMPLES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cps               (cps),
    .in_packet_count   (in_packet_count),
    .in_sample_count   (in_sample_count),
    .out_status        (out_status),
    .out_target_chunk  (out_target_chunk),
    .out_emitted       (out_emitted),
    .out_emitted_chunk (out_emitted_chunk),
    .out_last          (out_last)
  );

endmodule

>>> hw/rtl/ptwa_cfg.sv
// Configuration register file of the packet time window assigner.
// APB-style slave holding the counts-per-sample register; uses ptwa_pkg.
module ptwa_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptwa_pkg::ADDR_W-1:0]   paddr,
  input  logic [ptwa_pkg::DATA_W-1:0]   pwdata,
  output logic [ptwa_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [ptwa_pkg::CPS_W-1:0]    cps
);

  logic [ptwa_pkg::CPS_W-1:0] cps_r;
  logic [ptwa_pkg::CPS_W-1:0] cps_nxt;
  logic                       sel_cps;

  // Register decode: index is the byte address divided by four.
  assign sel_cps = (paddr[2] == ptwa_pkg::REG_CPS);

  // Write at the access cycle of a write transaction.
  always_comb begin
    cps_nxt = cps_r;
    if (psel && penable && pwrite && sel_cps) begin
      cps_nxt = pwdata[ptwa_pkg::CPS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cps_r <= ptwa_pkg::CPS_RESET;
    end else begin
      cps_r <= cps_nxt;
    end
  end

  // Read back; unmapped addresses read as zero.
  assign prdata = sel_cps ? {{(ptwa_pkg::DATA_W - ptwa_pkg::CPS_W){1'b0}}, cps_r}
                          : '0;
  assign pready = 1'b1;
  assign cps    = cps_r;

endmodule

>>> hw/rtl/ptwa_ctrl.sv
// Controller of the packet time window assigner: sequences the divider
// pass, the window update and the result transactions. Uses ptwa_pkg.
module ptwa_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_cmd,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ptwa_pkg::ptwa_cmd_t    cmd,
  input  ptwa_pkg::ptwa_stat_t   stat
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b00_0001,
    S_DIV    = 6'b00_0010,
    S_ADV    = 6'b00_0100,
    S_CLS    = 6'b00_1000,
    S_CMD    = 6'b01_0000,
    S_FLUSH2 = 6'b10_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   started_r, started_nxt;
  logic   finished_r, finished_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   cmd_r, cmd_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  // The output register can take a new result when empty or being drained.
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Next-state and command logic.
  always_comb begin
    state_nxt    = state_r;
    started_nxt  = started_r;
    finished_nxt = finished_r;
    cmd_nxt      = cmd_r;
    cmd          = '0;
    cmd.kind     = ptwa_pkg::K_PACKET;
    cmd.started  = started_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_cmd;
          if (in_cmd || finished_r) begin
            state_nxt = S_CMD;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_ADV;
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        started_nxt = 1'b1;
        state_nxt   = S_CLS;
      end
      S_CLS: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.kind     = ptwa_pkg::K_PACKET;
          state_nxt    = S_IDLE;
        end
      end
      S_CMD: begin
        // End of stream, or a packet after the end.
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
          if (!cmd_r) begin
            cmd.kind = ptwa_pkg::K_AFTER_END;
          end else if (finished_r) begin
            cmd.kind = ptwa_pkg::K_DOUBLE_END;
          end else begin
            finished_nxt = 1'b1;
            started_nxt  = 1'b1;
            if (started_r) begin
              cmd.kind  = ptwa_pkg::K_FLUSH_OLD;
              state_nxt = S_FLUSH2;
            end else begin
              cmd.kind = ptwa_pkg::K_FLUSH_NONE;
            end
          end
        end
      end
      S_FLUSH2: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.kind     = ptwa_pkg::K_FLUSH_NEW;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set on a load, cleared when the transaction completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      started_r   <= 1'b0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cmd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
      cmd_r       <= cmd_nxt;
    end
  end

endmodule

>>> hw/rtl/ptwa_dp.sv
// Datapath of the packet time window assigner: two-lane restoring divider,
// chunk window registers, classification and the output register.
// Uses ptwa_pkg; driven by ptwa_ctrl.
module ptwa_dp #(
  parameter int CHUNK_SAMPLES = ptwa_pkg::CHUNK_SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ptwa_pkg::ptwa_cmd_t            cmd,
  output ptwa_pkg::ptwa_stat_t           stat,
  input  logic [ptwa_pkg::CPS_W-1:0]     cps,
  input  logic [ptwa_pkg::TS_W-1:0]      in_packet_count,
  input  logic [ptwa_pkg::NS_W-1:0]      in_sample_count,
  output logic [2:0]                     out_status,
  output logic [ptwa_pkg::CHUNK_W-1:0]   out_target_chunk,
  output logic                           out_emitted,
  output logic [ptwa_pkg::CHUNK_W-1:0]   out_emitted_chunk,
  output logic                           out_last
);

  localparam int DIV_W   = ptwa_pkg::DIV_W;
  localparam int DVD_W   = ptwa_pkg::DVD_W;
  localparam int CNT_W   = ptwa_pkg::CNT_W;
  localparam int TS_W    = ptwa_pkg::TS_W;
  localparam int CHUNK_W = ptwa_pkg::CHUNK_W;
  localparam int CPS_W   = ptwa_pkg::CPS_W;
  localparam int SPAN_W  = ptwa_pkg::SPAN_W;
  localparam int BIAS_W  = ptwa_pkg::BIAS_W;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DVD_W-1:0] dvd;
  } lane_t;

  // One restoring step: the quotient bit shifts into the dividend register.
  function automatic lane_t lane_step(lane_t cur, logic [DIV_W-1:0] d);
    logic [DIV_W:0] sh;
    logic           ge;
    lane_t          res;
    sh      = {cur.rem, cur.dvd[DVD_W-1]};
    ge      = (sh >= {1'b0, d});
    res.rem = ge ? DIV_W'(sh - {1'b0, d}) : sh[DIV_W-1:0];
    res.dvd = {cur.dvd[DVD_W-2:0], ge};
    return res;
  endfunction

  lane_t                    lane_a_r, lane_a_nxt;
  lane_t                    lane_b_r, lane_b_nxt;
  logic [DIV_W-1:0]         dsr_r, dsr_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CHUNK_W-1:0]       older_r, older_nxt;
  logic                     emit_r, emit_nxt;
  logic [CHUNK_W-1:0]       emit_chunk_r, emit_chunk_nxt;

  logic [2:0]               status_r, status_nxt;
  logic [CHUNK_W-1:0]       target_r, target_nxt;
  logic                     oemit_r, oemit_nxt;
  logic [CHUNK_W-1:0]       ochunk_r, ochunk_nxt;
  logic                     last_r, last_nxt;

  logic [CPS_W-1:0]         cps_eff;
  logic [SPAN_W-1:0]        span_m;
  logic [BIAS_W-1:0]        bias;
  logic [TS_W-1:0]          q0;
  logic [TS_W-1:0]          c1;
  logic [CHUNK_W-1:0]       older_eff;
  logic                     adv;
  logic [TS_W-1:0]          a_w, a1_w, a2_w;
  ptwa_pkg::status_t        pkt_status;
  logic [CHUNK_W-1:0]       pkt_target;

  // Dividing the timestamp by counts-per-sample times the chunk length gives
  // the start chunk directly. Adding (samples + chunk - 1) * counts-per-sample
  // to the timestamp gives the rounded-up end chunk from the same divisor.
  assign cps_eff = (cps == '0) ? CPS_W'(1) : cps;
  assign span_m  = SPAN_W'(in_sample_count) + SPAN_W'(CHUNK_SAMPLES - 1);
  assign bias    = BIAS_W'(span_m) * BIAS_W'(cps_eff);

  // Lane A ends with the start chunk, lane B with the end chunk.
  assign q0  = lane_a_r.dvd[TS_W-1:0];
  assign c1  = (|lane_b_r.dvd[DVD_W-1:TS_W]) ? '1 : lane_b_r.dvd[TS_W-1:0];

  assign stat.div_done = (cnt_r == CNT_W'(DVD_W - 1));

  // Divider lanes and step counter.
  always_comb begin
    lane_a_nxt = lane_a_r;
    lane_b_nxt = lane_b_r;
    dsr_nxt    = dsr_r;
    cnt_nxt    = cnt_r;
    if (cmd.capture) begin
      lane_a_nxt.rem = '0;
      lane_a_nxt.dvd = {2'b00, in_packet_count};
      lane_b_nxt.rem = '0;
      lane_b_nxt.dvd = {2'b00, in_packet_count} + DVD_W'(bias);
      dsr_nxt        = DIV_W'(cps_eff) * DIV_W'(CHUNK_SAMPLES);
      cnt_nxt        = '0;
    end else if (cmd.step) begin
      lane_a_nxt = lane_step(lane_a_r, dsr_r);
      lane_b_nxt = lane_step(lane_b_r, dsr_r);
      cnt_nxt    = cnt_r + CNT_W'(1);
    end
  end

  // Window setup and advance by at most one chunk.
  always_comb begin
    older_eff      = cmd.started ? older_r : q0[CHUNK_W-1:0];
    adv            = (c1 > (TS_W'(older_eff) + TS_W'(2)));
    older_nxt      = older_r;
    emit_nxt       = emit_r;
    emit_chunk_nxt = emit_chunk_r;
    if (cmd.advance) begin
      older_nxt      = adv ? older_eff + CHUNK_W'(1) : older_eff;
      emit_nxt       = adv;
      emit_chunk_nxt = older_eff;
    end
  end

  // Placement of the packet against the older and the newer chunk.
  always_comb begin
    a_w  = TS_W'(older_r);
    a1_w = a_w + TS_W'(1);
    a2_w = a_w + TS_W'(2);
    pkt_target = '0;
    if (q0 >= a_w && c1 <= a1_w) begin
      pkt_status = ptwa_pkg::ST_PLACED;
      pkt_target = older_r;
    end else if (q0 >= a1_w && c1 <= a2_w) begin
      pkt_status = ptwa_pkg::ST_PLACED;
      pkt_target = a1_w[CHUNK_W-1:0];
    end else if (q0 < a2_w && c1 > a_w) begin
      pkt_status = ptwa_pkg::ST_STRADDLE;
    end else begin
      pkt_status = ptwa_pkg::ST_DROPPED;
    end
  end

  // Output register load.
  always_comb begin
    status_nxt = status_r;
    target_nxt = target_r;
    oemit_nxt  = oemit_r;
    ochunk_nxt = ochunk_r;
    last_nxt   = last_r;
    if (cmd.out_load) begin
      target_nxt = '0;
      oemit_nxt  = 1'b0;
      ochunk_nxt = '0;
      last_nxt   = 1'b1;
      unique case (cmd.kind)
        ptwa_pkg::K_PACKET: begin
          status_nxt = pkt_status;
          target_nxt = pkt_target;
          oemit_nxt  = emit_r;
          ochunk_nxt = emit_r ? emit_chunk_r : '0;
        end
        ptwa_pkg::K_AFTER_END: begin
          status_nxt = ptwa_pkg::ST_AFTER_END;
        end
        ptwa_pkg::K_DOUBLE_END: begin
          status_nxt = ptwa_pkg::ST_DOUBLE_END;
        end
        ptwa_pkg::K_FLUSH_NONE: begin
          status_nxt = ptwa_pkg::ST_FLUSH;
        end
        ptwa_pkg::K_FLUSH_OLD: begin
          status_nxt = ptwa_pkg::ST_FLUSH;
          oemit_nxt  = 1'b1;
          ochunk_nxt = older_r;
          last_nxt   = 1'b0;
        end
        ptwa_pkg::K_FLUSH_NEW: begin
          status_nxt = ptwa_pkg::ST_FLUSH;
          oemit_nxt  = 1'b1;
          ochunk_nxt = older_r + CHUNK_W'(1);
        end
        default: begin
          status_nxt = ptwa_pkg::ST_DROPPED;
        end
      endcase
    end
  end

  // Window state is reset; the rest is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= '0;
    end else begin
      older_r <= older_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lane_a_r     <= lane_a_nxt;
    lane_b_r     <= lane_b_nxt;
    dsr_r        <= dsr_nxt;
    cnt_r        <= cnt_nxt;
    emit_r       <= emit_nxt;
    emit_chunk_r <= emit_chunk_nxt;
    status_r     <= status_nxt;
    target_r     <= target_nxt;
    oemit_r      <= oemit_nxt;
    ochunk_r     <= ochunk_nxt;
    last_r       <= last_nxt;
  end

  assign out_status        = status_r;
  assign out_target_chunk  = target_r;
  assign out_emitted       = oemit_r;
  assign out_emitted_chunk = ochunk_r;
  assign out_last          = last_r;

endmodule
